// ===== sv/pcr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcr_pkg
// shared types, constants and fixed-point helpers for the contact resolver
// ----------------------------------------------------------------------------
package pcr_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [30:0] TIME_STEP_RST = 31'd1092;

    typedef logic signed [31:0] q_t;

    // one contact as it travels down the pipe
    typedef struct packed {
        q_t          v1x;
        q_t          v1y;
        q_t          v2x;
        q_t          v2y;
        q_t          ax;
        q_t          ay;
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [30:0] im1;
        logic [30:0] im2;
        q_t          pen;
        logic [16:0] rest;
    } contact_t;

    // result beat
    typedef struct packed {
        q_t   nv1x;
        q_t   nv1y;
        q_t   nv2x;
        q_t   nv2y;
        q_t   m1x;
        q_t   m1y;
        q_t   m2x;
        q_t   m2y;
        logic applied;
        logic moved;
    } result_t;

    function automatic q_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // product scaled down, truncated toward zero
    function automatic logic signed [65:0] qmul(input logic signed [33:0] a,
                                                input logic signed [33:0] b,
                                                input int fb);
        logic signed [67:0] p;
        logic signed [67:0] r;
        p = a * b;
        r = p >>> fb;
        if (p < 0 && (p & ((68'sd1 <<< fb) - 68'sd1)) != 0)
            r = r + 68'sd1;
        return r[65:0];
    endfunction

endpackage

// ===== sv/particle_contact_resolve_unit.sv =====
// values are Q16.16 at the default FRAC_BITS of 16
// pipe depth: 3 front stages, FRAC_BITS + 33 divider stages, 3 back stages
// throughput: one contact per cycle, set by the fully pipelined divider (one bit per stage),
// as long as the whole pipe advances: while the output register is empty or being taken
// reset: asynchronous active low, clears all valid bits and loads time_step with 1092
// ----------------------------------------------------------------------------
// particle_contact_resolve_unit
// pipelined 2d particle contact impulse and penetration resolver
// ----------------------------------------------------------------------------
module particle_contact_resolve_unit #(
    parameter int FRAC_BITS = pcr_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data,      // time_step
    input  logic         s_tvalid,
    output logic         s_tready,
    // v1x, v1y, v2x, v2y, ax, ay, nx[18], ny[18], im1[31], im2[31], pen, rest[17], pad
    input  logic [343:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // nv1x, nv1y, nv2x, nv2y, m1x, m1y, m2x, m2y, applied, moved, pad
    output logic [263:0] m_tdata
);
    import pcr_pkg::*;

    localparam logic [33:0] PCT_Q = 34'((((64'd4) << FRAC_BITS) + 64'd2) / 64'd5);

    logic [30:0] time_step_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_step_reg <= TIME_STEP_RST;
        else if (cfg_valid)
            time_step_reg <= cfg_data;
    end

    // output register, pipe moves when it is free
    logic    out_vld_reg;
    result_t out_reg;
    logic    en;
    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    contact_t c_in;
    assign c_in.v1x  = s_tdata[31:0];
    assign c_in.v1y  = s_tdata[63:32];
    assign c_in.v2x  = s_tdata[95:64];
    assign c_in.v2y  = s_tdata[127:96];
    assign c_in.ax   = s_tdata[159:128];
    assign c_in.ay   = s_tdata[191:160];
    assign c_in.nx   = s_tdata[209:192];
    assign c_in.ny   = s_tdata[227:210];
    assign c_in.im1  = s_tdata[258:228];
    assign c_in.im2  = s_tdata[289:259];
    assign c_in.pen  = s_tdata[321:290];
    assign c_in.rest = s_tdata[338:322];

    // stage 1: relative velocity, products with normal
    logic     v1_reg;
    contact_t c1_reg;
    q_t       rvx_n_reg, rvy_n_reg, ax_n_reg, ay_n_reg, scaled_reg;
    logic [32:0] tot1_reg;

    q_t rvx, rvy;
    assign rvx = sat32(66'(c_in.v1x) - 66'(c_in.v2x));
    assign rvy = sat32(66'(c_in.v1y) - 66'(c_in.v2y));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg     <= c_in;
            rvx_n_reg  <= sat32(qmul(34'(rvx), 34'(c_in.nx), FRAC_BITS));
            rvy_n_reg  <= sat32(qmul(34'(rvy), 34'(c_in.ny), FRAC_BITS));
            ax_n_reg   <= sat32(qmul(34'(c_in.ax), 34'(c_in.nx), FRAC_BITS));
            ay_n_reg   <= sat32(qmul(34'(c_in.ay), 34'(c_in.ny), FRAC_BITS));
            scaled_reg <= sat32(qmul(34'(c_in.pen), $signed(PCT_Q), FRAC_BITS));
            tot1_reg   <= {2'b0, c_in.im1} + {2'b0, c_in.im2};
        end
    end

    // stage 2: sums, newsep base, accsep
    logic     v2_reg;
    contact_t c2_reg;
    q_t       sep2_reg, newsep2_reg, accsep2_reg, scaled2_reg;
    logic [32:0] tot2_reg;
    q_t sep1, accdot1;
    assign sep1    = sat32(66'(rvx_n_reg) + 66'(rvy_n_reg));
    assign accdot1 = sat32(66'(ax_n_reg) + 66'(ay_n_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg      <= c1_reg;
            sep2_reg    <= sep1;
            newsep2_reg <= sat32(qmul(-34'(sep1), 34'({1'b0, c1_reg.rest}), FRAC_BITS));
            accsep2_reg <= sat32(qmul(34'(accdot1), 34'({1'b0, time_step_reg}), FRAC_BITS));
            scaled2_reg <= scaled_reg;
            tot2_reg    <= tot1_reg;
        end
    end

    // stage 3: restitution times accsep
    logic     v3_reg;
    contact_t c3_reg;
    q_t       sep3_reg, newsep3_reg, racc3_reg, scaled3_reg;
    logic     accneg3_reg;
    logic [32:0] tot3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg      <= c2_reg;
            sep3_reg    <= sep2_reg;
            newsep3_reg <= newsep2_reg;
            racc3_reg   <= sat32(qmul(34'({1'b0, c2_reg.rest}), 34'(accsep2_reg), FRAC_BITS));
            accneg3_reg <= accsep2_reg < 0;
            scaled3_reg <= scaled2_reg;
            tot3_reg    <= tot2_reg;
        end
    end

    // stage 4: clamp and delta, into divider
    q_t ns_adj, ns_fin, delta4;
    always_comb
    begin
        ns_adj = sat32(66'(newsep3_reg) + 66'(racc3_reg));
        ns_fin = newsep3_reg;
        if (accneg3_reg)
            ns_fin = (ns_adj < 0) ? '0 : ns_adj;
        delta4 = sat32(66'(ns_fin) - 66'(sep3_reg));
    end

    localparam int SIDE_W = $bits(contact_t) + 2;
    logic [SIDE_W-1:0] side_in, side_out;
    assign side_in = {c3_reg, sep3_reg <= 0 && tot3_reg != 0,
                      c3_reg.pen > 0 && tot3_reg != 0};

    logic dv;
    q_t   imp, per;
    pcr_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v3_reg),
        .num_a    (delta4),
        .num_b    (scaled3_reg),
        .den      ((tot3_reg == 0) ? 33'd1 : tot3_reg),
        .side_in  (side_in),
        .out_valid(dv),
        .quo_a    (imp),
        .quo_b    (per),
        .side_out (side_out)
    );

    contact_t cd;
    logic     app_d, mov_d;
    assign {cd, app_d, mov_d} = side_out;

    // stage 5: normal times impulse
    logic     v5_reg;
    contact_t c5_reg;
    logic     app5_reg, mov5_reg;
    q_t       ipx_reg, ipy_reg, mx_reg, my_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= dv;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c5_reg   <= cd;
            app5_reg <= app_d;
            mov5_reg <= mov_d;
            ipx_reg  <= sat32(qmul(34'(cd.nx), 34'(imp), FRAC_BITS));
            ipy_reg  <= sat32(qmul(34'(cd.ny), 34'(imp), FRAC_BITS));
            mx_reg   <= sat32(qmul(34'(cd.nx), 34'(per), FRAC_BITS));
            my_reg   <= sat32(qmul(34'(cd.ny), 34'(per), FRAC_BITS));
        end
    end

    // stage 6: scale by inverse masses
    logic     v6_reg;
    contact_t c6_reg;
    logic     app6_reg, mov6_reg;
    q_t       d1x_reg, d1y_reg, d2x_reg, d2y_reg, m1x_reg, m1y_reg, m2x_reg, m2y_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c6_reg   <= c5_reg;
            app6_reg <= app5_reg;
            mov6_reg <= mov5_reg;
            d1x_reg  <= sat32(qmul(34'(ipx_reg), 34'({1'b0, c5_reg.im1}), FRAC_BITS));
            d1y_reg  <= sat32(qmul(34'(ipy_reg), 34'({1'b0, c5_reg.im1}), FRAC_BITS));
            d2x_reg  <= sat32(qmul(34'(ipx_reg), 34'({1'b0, c5_reg.im2}), FRAC_BITS));
            d2y_reg  <= sat32(qmul(34'(ipy_reg), 34'({1'b0, c5_reg.im2}), FRAC_BITS));
            m1x_reg  <= sat32(qmul(34'(mx_reg), 34'({1'b0, c5_reg.im1}), FRAC_BITS));
            m1y_reg  <= sat32(qmul(34'(my_reg), 34'({1'b0, c5_reg.im1}), FRAC_BITS));
            m2x_reg  <= sat32(-qmul(34'(mx_reg), 34'({1'b0, c5_reg.im2}), FRAC_BITS));
            m2y_reg  <= sat32(-qmul(34'(my_reg), 34'({1'b0, c5_reg.im2}), FRAC_BITS));
        end
    end

    // stage 7: final adds into the output register
    result_t res_next;
    always_comb
    begin
        res_next.applied = app6_reg;
        res_next.moved   = mov6_reg;
        res_next.nv1x = app6_reg ? sat32(66'(c6_reg.v1x) + 66'(d1x_reg)) : c6_reg.v1x;
        res_next.nv1y = app6_reg ? sat32(66'(c6_reg.v1y) + 66'(d1y_reg)) : c6_reg.v1y;
        res_next.nv2x = app6_reg ? sat32(66'(c6_reg.v2x) - 66'(d2x_reg)) : c6_reg.v2x;
        res_next.nv2y = app6_reg ? sat32(66'(c6_reg.v2y) - 66'(d2y_reg)) : c6_reg.v2y;
        res_next.m1x  = mov6_reg ? m1x_reg : '0;
        res_next.m1y  = mov6_reg ? m1y_reg : '0;
        res_next.m2x  = mov6_reg ? m2x_reg : '0;
        res_next.m2y  = mov6_reg ? m2y_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= v6_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= res_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_reg.moved, out_reg.applied,
                       out_reg.m2y, out_reg.m2x, out_reg.m1y, out_reg.m1x,
                       out_reg.nv2y, out_reg.nv2x, out_reg.nv1y, out_reg.nv1x};

endmodule

// ===== sv/pcr_div.sv =====
// ----------------------------------------------------------------------------
// pcr_div
// pipelined restoring divider, one quotient bit per stage, with side payload
// ----------------------------------------------------------------------------
module pcr_div #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic signed [31:0] num_a,   // dividend a, quotient a*2^f/den
    input  logic signed [31:0] num_b,
    input  logic [32:0]       den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic signed [31:0] quo_a,
    output logic signed [31:0] quo_b,
    output logic [SIDE_W-1:0] side_out
);
    import pcr_pkg::*;

    localparam int NW = 32 + FRAC_BITS;   // magnitude bits of scaled dividend
    localparam int RW = 34;               // remainder width

    logic              vld_reg   [NW+1];
    logic [NW-1:0]     na_reg    [NW+1];
    logic [NW-1:0]     nb_reg    [NW+1];
    logic [RW-1:0]     ra_reg    [NW+1];
    logic [RW-1:0]     rb_reg    [NW+1];
    logic              sa_reg    [NW+1];
    logic              sb_reg    [NW+1];
    logic [32:0]       den_reg   [NW+1];
    logic [SIDE_W-1:0] side_reg  [NW+1];

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    assign mag_a = num_a[31] ? 32'(-num_a) : num_a;
    assign mag_b = num_b[31] ? 32'(-num_b) : num_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NW; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i <= NW; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            na_reg[0]   <= {mag_a, {FRAC_BITS{1'b0}}};
            nb_reg[0]   <= {mag_b, {FRAC_BITS{1'b0}}};
            ra_reg[0]   <= '0;
            rb_reg[0]   <= '0;
            sa_reg[0]   <= num_a[31];
            sb_reg[0]   <= num_b[31];
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
            for (int i = 1; i <= NW; i++)
            begin
                logic [RW-1:0] ta;
                logic [RW-1:0] tb;
                ta = {ra_reg[i-1][RW-2:0], na_reg[i-1][NW-1]};
                tb = {rb_reg[i-1][RW-2:0], nb_reg[i-1][NW-1]};
                if (ta >= {1'b0, den_reg[i-1]})
                begin
                    ra_reg[i] <= ta - {1'b0, den_reg[i-1]};
                    na_reg[i] <= {na_reg[i-1][NW-2:0], 1'b1};
                end
                else
                begin
                    ra_reg[i] <= ta;
                    na_reg[i] <= {na_reg[i-1][NW-2:0], 1'b0};
                end
                if (tb >= {1'b0, den_reg[i-1]})
                begin
                    rb_reg[i] <= tb - {1'b0, den_reg[i-1]};
                    nb_reg[i] <= {nb_reg[i-1][NW-2:0], 1'b1};
                end
                else
                begin
                    rb_reg[i] <= tb;
                    nb_reg[i] <= {nb_reg[i-1][NW-2:0], 1'b0};
                end
                sa_reg[i]   <= sa_reg[i-1];
                sb_reg[i]   <= sb_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // quotient bits now sit in na/nb; sign then saturate
    logic signed [NW:0] qa;
    logic signed [NW:0] qb;
    assign qa = sa_reg[NW] ? -$signed({1'b0, na_reg[NW]}) : $signed({1'b0, na_reg[NW]});
    assign qb = sb_reg[NW] ? -$signed({1'b0, nb_reg[NW]}) : $signed({1'b0, nb_reg[NW]});

    assign out_valid = vld_reg[NW];
    assign quo_a     = sat32(66'(qa));
    assign quo_b     = sat32(66'(qb));
    assign side_out  = side_reg[NW];

endmodule

// ===== sv/pcr_checker.sv =====
// ----------------------------------------------------------------------------
// pcr_checker
// port-level checks on the contact resolver
// ----------------------------------------------------------------------------
module pcr_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [263:0] m_tdata
);
    // a clear moved flag implies zeroed move fields
    a_moved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[257] |-> m_tdata[255:128] == '0)
        else $error("move fields set without moved flag");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // a free output means the input side is open
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[263:258] == '0)
        else $error("padding bits set");

endmodule

bind particle_contact_resolve_unit pcr_checker u_pcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/particle_contact_resolve_unit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_contact_resolve_unit_checker
// watches the config, input and result channels, predicts each result from the
// contact fields and the current time_step, and counts every mismatch
// ----------------------------------------------------------------------------
module particle_contact_resolve_unit_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [30:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [343:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [263:0] m_tdata,
    output int           fail_count,
    output int           pending_count,
    output int           result_count
);
    import pcr_pkg::*;

    localparam longint FRAC    = 16;
    localparam longint ONE     = 64'sd1 << FRAC;
    localparam longint EIGHTY  = ((64'sd4 << FRAC) + 2) / 5;
    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint NEG_MAX = -64'sd2147483648;

    longint  step_now;
    result_t expected_results[$];

    function automatic longint clip(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < NEG_MAX)
            return NEG_MAX;
        return v;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return (a * b) / ONE;
    endfunction

    function automatic longint fdiv(input longint a, input longint b);
        return (a * ONE) / b;
    endfunction

    function automatic result_t resolve_contact(input contact_t c, input longint dt);
        result_t r;
        longint v1x, v1y, v2x, v2y, ax, ay, nx, ny, im1, im2, pen, rest, total;
        longint rvx, rvy, sep, newsep, accdot, accsep, delta, imp, ipx, ipy;
        longint scaled, per, mx, my;
        v1x = 64'(c.v1x); v1y = 64'(c.v1y); v2x = 64'(c.v2x); v2y = 64'(c.v2y);
        ax = 64'(c.ax); ay = 64'(c.ay); nx = 64'(c.nx); ny = 64'(c.ny);
        im1 = 64'(c.im1); im2 = 64'(c.im2); pen = 64'(c.pen); rest = 64'(c.rest);
        total = im1 + im2;
        r = '0;
        r.nv1x = 32'(v1x); r.nv1y = 32'(v1y); r.nv2x = 32'(v2x); r.nv2y = 32'(v2y);
        rvx = clip(v1x - v2x);
        rvy = clip(v1y - v2y);
        sep = clip(clip(fmul(rvx, nx)) + clip(fmul(rvy, ny)));
        if (sep <= 0 && total > 0)
        begin
            newsep = clip(fmul(-sep, rest));
            accdot = clip(clip(fmul(ax, nx)) + clip(fmul(ay, ny)));
            accsep = clip(fmul(accdot, dt));
            if (accsep < 0)
            begin
                newsep = clip(newsep + clip(fmul(rest, accsep)));
                if (newsep < 0)
                    newsep = 0;
            end
            delta = clip(newsep - sep);
            imp = clip(fdiv(delta, total));
            ipx = clip(fmul(nx, imp));
            ipy = clip(fmul(ny, imp));
            r.nv1x = 32'(clip(v1x + clip(fmul(ipx, im1))));
            r.nv1y = 32'(clip(v1y + clip(fmul(ipy, im1))));
            r.nv2x = 32'(clip(v2x - clip(fmul(ipx, im2))));
            r.nv2y = 32'(clip(v2y - clip(fmul(ipy, im2))));
            r.applied = 1'b1;
        end
        if (pen > 0 && total > 0)
        begin
            scaled = clip(fmul(pen, EIGHTY));
            per = clip(fdiv(scaled, total));
            mx = clip(fmul(nx, per));
            my = clip(fmul(ny, per));
            r.m1x = 32'(clip(fmul(mx, im1)));
            r.m1y = 32'(clip(fmul(my, im1)));
            r.m2x = 32'(clip(-fmul(mx, im2)));
            r.m2y = 32'(clip(-fmul(my, im2)));
            r.moved = 1'b1;
        end
        return r;
    endfunction

    // tdata holds the first field in the lowest bits
    function automatic contact_t unpack_contact(input logic [343:0] d);
        contact_t c;
        c.v1x = d[31:0];     c.v1y = d[63:32];
        c.v2x = d[95:64];    c.v2y = d[127:96];
        c.ax = d[159:128];   c.ay = d[191:160];
        c.nx = d[209:192];   c.ny = d[227:210];
        c.im1 = d[258:228];  c.im2 = d[289:259];
        c.pen = d[321:290];  c.rest = d[338:322];
        return c;
    endfunction

    function automatic result_t unpack_result(input logic [263:0] d);
        result_t r;
        r.nv1x = d[31:0];    r.nv1y = d[63:32];
        r.nv2x = d[95:64];   r.nv2y = d[127:96];
        r.m1x = d[159:128];  r.m1y = d[191:160];
        r.m2x = d[223:192];  r.m2y = d[255:224];
        r.applied = d[256];  r.moved = d[257];
        return r;
    endfunction

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            step_now     <= 1092;
            fail_count   <= 0;
            result_count <= 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                step_now <= 64'(cfg_data);
            if (s_tvalid && s_tready)
                expected_results.push_back(resolve_contact(unpack_contact(s_tdata), step_now));
            if (m_tvalid && m_tready)
            begin
                got = unpack_result(m_tdata);
                result_count <= result_count + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/particle_contact_resolve_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_contact_resolve_unit_tb
// directed and random contacts under several idling phases and time_step
// settings; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module particle_contact_resolve_unit_tb;
    import pcr_pkg::*;

    localparam int DRAIN_CYCLES = 120;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [30:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [343:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;
    int           fail_count;
    int           pending_count;
    int           result_count;
    int           sent_count;
    int           src_idle_pct;
    int           sink_stall_pct;
    logic         sink_hold;

    particle_contact_resolve_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    particle_contact_resolve_unit_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", pending_count);
        $display("** particle_contact_resolve_unit: FAILED **");
        $finish;
    end

    // receiver: random stalls plus a long hold-off when asked
    always @(negedge clk)
    begin
        if (sink_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [343:0] pack_contact(input contact_t c);
        return {5'd0, c.rest, c.pen, c.im2, c.im1, c.ny, c.nx,
                c.ay, c.ax, c.v2y, c.v2x, c.v1y, c.v1x};
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(8'hff)) - 128) <<< 16;
            default: return 32'($signed($urandom_range(20'hfffff)) - 524288) <<< 4;
        endcase
    endfunction

    function automatic contact_t random_contact();
        contact_t c;
        c.v1x = rand_q(); c.v1y = rand_q();
        c.v2x = rand_q(); c.v2y = rand_q();
        c.ax = rand_q();  c.ay = rand_q();
        if ($urandom_range(3) == 0)
        begin
            c.nx = 18'($urandom); c.ny = 18'($urandom);
        end
        else
        begin
            c.nx = 18'($signed($urandom_range(131072)) - 65536);
            c.ny = 18'($signed($urandom_range(131072)) - 65536);
        end
        case ($urandom_range(3))
            0: c.im1 = 31'($urandom);
            1: c.im1 = '0;
            default: c.im1 = 31'($urandom_range(262144));
        endcase
        case ($urandom_range(3))
            0: c.im2 = 31'($urandom);
            1: c.im2 = '0;
            default: c.im2 = 31'($urandom_range(262144));
        endcase
        if ($urandom_range(5) == 0)
        begin
            c.v2x = '0; c.v2y = '0; c.im2 = '0;
        end
        c.pen = rand_q();
        c.rest = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(65536));
        return c;
    endfunction

    task automatic send_contact(input contact_t c);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_contact(c);
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent_count++;
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_step(input logic [30:0] val);
        go_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_contacts();
        contact_t c;
        c = '0;
        c.v1x = 32'sh00010000; c.nx = -18'sd65536; c.im1 = 31'h10000; c.rest = 17'h8000;
        send_contact(c);                              // closing head on
        c.v1x = -32'sh00010000;
        send_contact(c);                              // separating
        c.v1x = '0; c.v1y = 32'sh00030000;
        send_contact(c);                              // zero separating velocity
        c.im1 = '0; c.pen = 32'sh00020000;
        send_contact(c);                              // both immovable
        c.im1 = 31'h7fffffff; c.im2 = 31'h7fffffff; c.pen = 32'sh7fffffff;
        c.v1x = 32'sh7fffffff; c.v2x = 32'sh80000000; c.nx = -18'sd65536;
        c.rest = 17'h1ffff;
        send_contact(c);                              // saturation extremes
        c.pen = 32'sh80000000; c.ax = 32'sh80000000; c.ay = 32'sh7fffffff;
        c.ny = 18'sh1ffff; c.nx = 18'sh20000;
        send_contact(c);                              // no penetration, odd normal
        c.pen = '0; c.ax = 32'shffff0000; c.nx = 18'sd65536; c.ny = '0;
        c.v1x = -32'sh00010000; c.v2x = '0; c.im2 = '0; c.im1 = 31'h1; c.rest = 17'h10000;
        send_contact(c);                              // accel closing, clamp
        c.v2x = 32'sh00010000; c.v2y = -32'sd1; c.im2 = 31'h20000; c.pen = 32'sd1;
        c.rest = '0;
        send_contact(c);
        repeat (12) send_contact(random_contact());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sink_hold = 1'b0;
        sent_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_contacts();
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_step(31'd0);
                1: write_step(31'h7fffffff);
                2: write_step(31'd1092);
                3: write_step(31'($urandom));
                4: write_step(31'h10000);
                default: write_step(31'($urandom_range(65536)));
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            for (int i = 0; i < 205; i++)
            begin
                if (ph == 0 && i == 20)
                    fork
                        begin
                            sink_hold = 1'b1;
                            repeat (300) @(negedge clk);
                            sink_hold = 1'b0;
                        end
                    join_none
                if (ph == 4 && i == 100)
                    go_idle();
                send_contact(random_contact());
            end
        end
        go_idle();

        $display("%0d contacts sent, %0d results checked over six time_step settings",
                 sent_count, result_count);
        $display("idling phases: none, sender 88%%, receiver 88%%, both 16%%, long stall");
        if (fail_count == 0)
            $display("** particle_contact_resolve_unit: PASSED **");
        else
            $display("** particle_contact_resolve_unit: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pcr_pkg.sv
sv/pcr_div.sv
sv/particle_contact_resolve_unit.sv
sv/pcr_checker.sv
tb/sv/particle_contact_resolve_unit_checker.sv
tb/sv/particle_contact_resolve_unit_tb.sv
